// ===== rtl/segment_intersection_top_assert.svh =====
// Assertion macros for the segment intersection block.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define SEGMENT_INTERSECTION_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SEGI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SEGI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/segi_pkg.sv =====
// Types, constants and saturation helpers for the segment intersection block.
// No dependencies.
package segi_pkg;

  localparam int IN_W    = 16;
  localparam int PARAM_W = 20;
  localparam int PT_W    = 32;
  localparam int PT_FRAC = 8;
  localparam int QUO_W   = 32;

  typedef struct packed {
    logic signed [IN_W-1:0] ax;
    logic signed [IN_W-1:0] ay;
    logic signed [IN_W-1:0] bx;
    logic signed [IN_W-1:0] by_coord;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cy;
    logic signed [IN_W-1:0] dx_coord;
    logic signed [IN_W-1:0] dy_coord;
  } in_t;

  typedef struct packed {
    logic                      intersect_res;
    logic                      parallel;
    logic                      collinear;
    logic signed [PARAM_W-1:0] param_r;
    logic signed [PARAM_W-1:0] param_s;
    logic signed [PT_W-1:0]    point_x;
    logic signed [PT_W-1:0]    point_y;
  } out_t;

  // per-transaction flags and fallback point carried alongside the dividers
  typedef struct packed {
    logic                   hit;
    logic                   par;
    logic                   col;
    logic                   dz;
    logic                   dneg;
    logic                   neg_r;
    logic                   neg_s;
    logic                   neg_x;
    logic                   neg_y;
    logic signed [PT_W-1:0] pax;
    logic signed [PT_W-1:0] pay;
  } side_t;

  function automatic logic signed [PARAM_W-1:0] sat_param(
    input logic [QUO_W-1:0] q, input logic ovf, input logic neg);
    logic [QUO_W-1:0] lim_neg;
    logic [QUO_W-1:0] lim_pos;
    logic signed [PARAM_W-1:0] res;
    lim_neg = QUO_W'(1) << (PARAM_W - 1);
    lim_pos = lim_neg - QUO_W'(1);
    if (neg) begin
      if (ovf || (q > lim_neg)) res = {1'b1, {(PARAM_W-1){1'b0}}};
      else res = -$signed(q[PARAM_W-1:0]);
    end else begin
      if (ovf || (q > lim_pos)) res = {1'b0, {(PARAM_W-1){1'b1}}};
      else res = $signed(q[PARAM_W-1:0]);
    end
    return res;
  endfunction

  function automatic logic signed [PT_W-1:0] sat_point(
    input logic [QUO_W-1:0] q, input logic ovf, input logic neg);
    logic [QUO_W-1:0] lim_neg;
    logic [QUO_W-1:0] lim_pos;
    logic signed [PT_W-1:0] res;
    lim_neg = QUO_W'(1) << (PT_W - 1);
    lim_pos = lim_neg - QUO_W'(1);
    if (neg) begin
      if (ovf || (q > lim_neg)) res = {1'b1, {(PT_W-1){1'b0}}};
      else res = -$signed(q[PT_W-1:0]);
    end else begin
      if (ovf || (q > lim_pos)) res = {1'b0, {(PT_W-1){1'b1}}};
      else res = $signed(q[PT_W-1:0]);
    end
    return res;
  endfunction

endpackage

// ===== rtl/segi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Standalone; holds all stages while en_i is low.
module segi_div #(
  parameter int NB = 60,
  parameter int DB = 34,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NB-1:0] num_i,
  input  logic [DB-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int RW = ((NB > DB + QW) ? NB : DB + QW) + 1;

  logic [RW-1:0] rem_q [QW+1];
  logic [DB-1:0] dv_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          ovf_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      dv_q[0]  <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= RW'(num_i) >= (RW'(den_i) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = RW'(dv_q[k]) << B;
    assign ge = rem_q[k] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? (rem_q[k] - sh) : rem_q[k];
        dv_q[k+1]  <= dv_q[k];
        quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ===== rtl/segment_intersection_top.sv =====
// Segment intersection: one pair of 2-D segments in, one result out per transaction.
// The pipeline has 7 arithmetic stages, 33 divider stages and an output register, and
// one transaction is taken every cycle while the output is taken; the four dividers
// produce one quotient bit per stage, which sets the depth. A held output stalls the
// whole pipeline. Uses segi_pkg, segi_div and segment_intersection_top_assert.svh.
module segment_intersection_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  segi_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output segi_pkg::out_t out_data_o
);
  import segi_pkg::*;
  `include "segment_intersection_top_assert.svh"

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int NW  = 2 * DW;
  localparam int PNW = NW + DW;
  localparam int RNB = NW + FRAC_BITS + 1;
  localparam int PXB = PNW + PT_FRAC + 1;
  localparam int DL  = QUO_W + 1;

  logic en;
  logic [6:0]    v_q;
  logic [DL-1:0] vd_q;
  logic          out_valid_q;
  out_t          out_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      vd_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[5:0], in_valid_i};
      vd_q        <= {vd_q[DL-2:0], v_q[6]};
      out_valid_q <= vd_q[DL-1];
    end
  end

  // stage 1: coordinates and differences
  logic signed [CW-1:0] ax_c, ay_c, bx_c, by_c, cx_c, cy_c, dx_c, dy_c;
  assign ax_c = $signed(CW'($unsigned(in_data_i.ax)));
  assign ay_c = $signed(CW'($unsigned(in_data_i.ay)));
  assign bx_c = $signed(CW'($unsigned(in_data_i.bx)));
  assign by_c = $signed(CW'($unsigned(in_data_i.by_coord)));
  assign cx_c = $signed(CW'($unsigned(in_data_i.cx)));
  assign cy_c = $signed(CW'($unsigned(in_data_i.cy)));
  assign dx_c = $signed(CW'($unsigned(in_data_i.dx_coord)));
  assign dy_c = $signed(CW'($unsigned(in_data_i.dy_coord)));

  logic signed [DW-1:0] ex1_q, ey1_q, fx1_q, fy1_q, gx1_q, gy1_q;
  logic signed [CW-1:0] ax1_q, ay1_q;
  // stage 2
  logic signed [NW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DW-1:0] ex2_q, ey2_q;
  logic signed [CW-1:0] ax2_q, ay2_q;
  // stage 3
  logic signed [NW-1:0] den3_q, rn3_q, sn3_q;
  logic signed [DW-1:0] ex3_q, ey3_q;
  logic signed [CW-1:0] ax3_q, ay3_q;
  // stage 4
  logic signed [PNW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic [NW-1:0]         ar4_q, as4_q, ad4_q;
  side_t                 sd4_q;
  // stage 5
  logic signed [PNW-1:0] xn5_q, yn5_q;
  logic [RNB-1:0]        nr5_q, ns5_q;
  logic [NW-1:0]         dd5_q, ad5_q;
  side_t                 sd5_q;
  // stage 6
  logic [PNW-1:0]        axn6_q, ayn6_q;
  logic [RNB-1:0]        nr6_q, ns6_q;
  logic [NW-1:0]         dd6_q, ad6_q;
  side_t                 sd6_q;
  side_t                 sd6_d;
  // stage 7
  logic [PXB-1:0]        nx7_q, ny7_q;
  logic [RNB-1:0]        nr7_q, ns7_q;
  logic [NW-1:0]         dd7_q;
  side_t                 sd7_q;

  side_t side_q [DL];

  // stage 4 combinational: exact range test and magnitudes
  logic signed [NW:0] dn4, rr4, ss4;
  logic               dz4, rz4, hit4;
  side_t              sd4_d;
  always_comb begin
    dz4 = (den3_q == '0);
    rz4 = (rn3_q == '0);
    if (den3_q[NW-1]) begin
      dn4 = -(NW+1)'(den3_q);
      rr4 = -(NW+1)'(rn3_q);
      ss4 = -(NW+1)'(sn3_q);
    end else begin
      dn4 = (NW+1)'(den3_q);
      rr4 = (NW+1)'(rn3_q);
      ss4 = (NW+1)'(sn3_q);
    end
    hit4 = !dz4 && !rr4[NW] && (rr4 <= dn4) && !ss4[NW] && (ss4 <= dn4);
    sd4_d.hit   = hit4;
    sd4_d.par   = dz4 && !rz4;
    sd4_d.col   = dz4 && rz4;
    sd4_d.dz    = dz4;
    sd4_d.dneg  = den3_q[NW-1];
    sd4_d.neg_r = rn3_q[NW-1] ^ den3_q[NW-1];
    sd4_d.neg_s = sn3_q[NW-1] ^ den3_q[NW-1];
    sd4_d.neg_x = 1'b0;
    sd4_d.neg_y = 1'b0;
    sd4_d.pax   = PT_W'(ax3_q) <<< PT_FRAC;
    sd4_d.pay   = PT_W'(ay3_q) <<< PT_FRAC;
  end

  // stage 6 combinational: point quotient signs
  always_comb begin
    sd6_d       = sd5_q;
    sd6_d.neg_x = xn5_q[PNW-1] ^ sd5_q.dneg;
    sd6_d.neg_y = yn5_q[PNW-1] ^ sd5_q.dneg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex1_q <= DW'(bx_c) - DW'(ax_c);
      ey1_q <= DW'(by_c) - DW'(ay_c);
      fx1_q <= DW'(dx_c) - DW'(cx_c);
      fy1_q <= DW'(dy_c) - DW'(cy_c);
      gx1_q <= DW'(ax_c) - DW'(cx_c);
      gy1_q <= DW'(ay_c) - DW'(cy_c);
      ax1_q <= ax_c;
      ay1_q <= ay_c;

      p0_q  <= NW'(ex1_q) * NW'(fy1_q);
      p1_q  <= NW'(ey1_q) * NW'(fx1_q);
      p2_q  <= NW'(gy1_q) * NW'(fx1_q);
      p3_q  <= NW'(gx1_q) * NW'(fy1_q);
      p4_q  <= NW'(gy1_q) * NW'(ex1_q);
      p5_q  <= NW'(gx1_q) * NW'(ey1_q);
      ex2_q <= ex1_q;
      ey2_q <= ey1_q;
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;

      den3_q <= p0_q - p1_q;
      rn3_q  <= p2_q - p3_q;
      sn3_q  <= p4_q - p5_q;
      ex3_q  <= ex2_q;
      ey3_q  <= ey2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;

      m0_q  <= PNW'(ax3_q) * PNW'(den3_q);
      m1_q  <= PNW'(rn3_q) * PNW'(ex3_q);
      m2_q  <= PNW'(ay3_q) * PNW'(den3_q);
      m3_q  <= PNW'(rn3_q) * PNW'(ey3_q);
      ar4_q <= rn3_q[NW-1] ? $unsigned(-rn3_q) : $unsigned(rn3_q);
      as4_q <= sn3_q[NW-1] ? $unsigned(-sn3_q) : $unsigned(sn3_q);
      ad4_q <= den3_q[NW-1] ? $unsigned(-den3_q) : $unsigned(den3_q);
      sd4_q <= sd4_d;

      xn5_q <= m0_q + m1_q;
      yn5_q <= m2_q + m3_q;
      nr5_q <= (RNB'(ar4_q) << (FRAC_BITS + 1)) + RNB'(ad4_q);
      ns5_q <= (RNB'(as4_q) << (FRAC_BITS + 1)) + RNB'(ad4_q);
      dd5_q <= ad4_q << 1;
      ad5_q <= ad4_q;
      sd5_q <= sd4_q;

      axn6_q <= xn5_q[PNW-1] ? $unsigned(-xn5_q) : $unsigned(xn5_q);
      ayn6_q <= yn5_q[PNW-1] ? $unsigned(-yn5_q) : $unsigned(yn5_q);
      nr6_q  <= nr5_q;
      ns6_q  <= ns5_q;
      dd6_q  <= dd5_q;
      ad6_q  <= ad5_q;
      sd6_q  <= sd6_d;

      nx7_q <= (PXB'(axn6_q) << (PT_FRAC + 1)) + PXB'(ad6_q);
      ny7_q <= (PXB'(ayn6_q) << (PT_FRAC + 1)) + PXB'(ad6_q);
      nr7_q <= nr6_q;
      ns7_q <= ns6_q;
      dd7_q <= dd6_q;
      sd7_q <= sd6_q;

      side_q[0] <= sd7_q;
      for (int k = 1; k < DL; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  logic [QUO_W-1:0] qr, qs, qx, qy;
  logic             or_r, or_s, or_x, or_y;

  segi_div #(.NB(RNB), .DB(NW), .QW(QUO_W)) u_div_r (
    .clk_i, .en_i(en), .num_i(nr7_q), .den_i(dd7_q), .quo_o(qr), .ovf_o(or_r));
  segi_div #(.NB(RNB), .DB(NW), .QW(QUO_W)) u_div_s (
    .clk_i, .en_i(en), .num_i(ns7_q), .den_i(dd7_q), .quo_o(qs), .ovf_o(or_s));
  segi_div #(.NB(PXB), .DB(NW), .QW(QUO_W)) u_div_x (
    .clk_i, .en_i(en), .num_i(nx7_q), .den_i(dd7_q), .quo_o(qx), .ovf_o(or_x));
  segi_div #(.NB(PXB), .DB(NW), .QW(QUO_W)) u_div_y (
    .clk_i, .en_i(en), .num_i(ny7_q), .den_i(dd7_q), .quo_o(qy), .ovf_o(or_y));

  side_t sd_o;
  out_t  out_d;
  assign sd_o = side_q[DL-1];

  always_comb begin
    out_d.intersect_res = sd_o.hit;
    out_d.parallel      = sd_o.par;
    out_d.collinear     = sd_o.col;
    if (sd_o.dz) begin
      out_d.param_r = '0;
      out_d.param_s = '0;
      out_d.point_x = sd_o.pax;
      out_d.point_y = sd_o.pay;
    end else begin
      out_d.param_r = sat_param(qr, or_r, sd_o.neg_r);
      out_d.param_s = sat_param(qs, or_s, sd_o.neg_s);
      out_d.point_x = sat_point(qx, or_x, sd_o.neg_x);
      out_d.point_y = sat_point(qy, or_y, sd_o.neg_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  `SEGI_ASSERT_IMP(a_flags_onehot, out_valid_o,
    $onehot0({out_data_o.intersect_res, out_data_o.parallel, out_data_o.collinear}),
    "result flags not exclusive")
  `SEGI_ASSERT_IMP(a_degenerate_zero,
    out_valid_o && (out_data_o.parallel || out_data_o.collinear),
    (out_data_o.param_r == '0) && (out_data_o.param_s == '0),
    "nonzero parameter with zero denominator")
  `SEGI_ASSERT_IMP(a_hit_nonneg, out_valid_o && out_data_o.intersect_res,
    !out_data_o.param_r[PARAM_W-1] && !out_data_o.param_s[PARAM_W-1],
    "negative parameter on intersection")
  `SEGI_ASSERT_NXT(a_stall_holds, !en,
    $stable(v_q) && $stable(vd_q), "pipeline moved during stall")

endmodule

// ===== bench/segment_intersection_top_tb.sv =====
// Self-checking testbench for segment_intersection_top: random and directed segment pairs,
// results predicted in exact integer arithmetic and compared field by field in order.
// Depends on segi_pkg and the segment_intersection_top RTL.
module segment_intersection_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import segi_pkg::*;

  localparam int  LATENCY   = 41;
  localparam int  MAX_CYCLE = 400000;
  localparam longint PMAX = 524287;
  localparam longint PMIN = -524288;
  localparam longint XMAX = 2147483647;
  localparam longint XMIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  out_t   expected_q[$];
  int     errors = 0;
  int     n_sent = 0;
  int     n_hit = 0, n_par = 0, n_col = 0;
  longint cycle = 0;
  bit     sink_busy = 1'b1;

  segment_intersection_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("%0t timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // round(n * 2^sh / d) ties away from zero, clamped
  function automatic longint div_round(longint n, longint d, int sh, longint lo,
                                       longint hi);
    bit     neg;
    longint an, ad, q;
    neg = (n < 0) != (d < 0);
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = ((an <<< (sh + 1)) + ad) / (ad * 2);
    if (neg) return (q > -lo) ? lo : -q;
    return (q > hi) ? hi : q;
  endfunction

  function automatic out_t predict_crossing(in_t t);
    longint ax, ay, bx, by, cx, cy, dx, dy, ex, ey, fx, fy, gx, gy;
    longint den, rn, sn, dn, rr, ss, r, s, px, py;
    out_t o;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by_coord;
    cx = t.cx; cy = t.cy; dx = t.dx_coord; dy = t.dy_coord;
    ex = bx - ax; ey = by - ay; fx = dx - cx; fy = dy - cy;
    gx = ax - cx; gy = ay - cy;
    den = ex * fy - ey * fx;
    rn = gy * fx - gx * fy;
    sn = gy * ex - gx * ey;
    o = '0;
    if (den == 0) begin
      o.collinear = (rn == 0);
      o.parallel = (rn != 0);
      px = ax * 256;
      py = ay * 256;
      r = 0;
      s = 0;
    end else begin
      dn = den; rr = rn; ss = sn;
      if (dn < 0) begin
        dn = -dn; rr = -rr; ss = -ss;
      end
      o.intersect_res = rr >= 0 && rr <= dn && ss >= 0 && ss <= dn;
      r = div_round(rn, den, 16, PMIN, PMAX);
      s = div_round(sn, den, 16, PMIN, PMAX);
      px = div_round(ax * den + rn * ex, den, 8, XMIN, XMAX);
      py = div_round(ay * den + rn * ey, den, 8, XMIN, XMAX);
    end
    o.param_r = r[PARAM_W-1:0];
    o.param_s = s[PARAM_W-1:0];
    o.point_x = px[PT_W-1:0];
    o.point_y = py[PT_W-1:0];
    return o;
  endfunction

  // valid stays high into the next call so back-to-back transactions need no gap
  task automatic send_pair(in_t t);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    expected_q.push_back(predict_crossing(t));
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pts(int ax, int ay, int bx, int by, int cx, int cy, int dx, int dy);
    in_t t;
    t.ax = IN_W'(ax); t.ay = IN_W'(ay); t.bx = IN_W'(bx); t.by_coord = IN_W'(by);
    t.cx = IN_W'(cx); t.cy = IN_W'(cy); t.dx_coord = IN_W'(dx); t.dy_coord = IN_W'(dy);
    send_pair(t);
  endtask

  // result sink with random backpressure
  always @(negedge clk_i) begin
    if (!sink_busy) out_ready_i <= 1'b1;
    else out_ready_i <= (gap_len() == 0);
  end

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.intersect_res) n_hit++;
        if (e.parallel) n_par++;
        if (e.collinear) n_col++;
        if (out_data_o.intersect_res !== e.intersect_res)
          $display("%0t intersect_res exp %0d got %0d", $time, e.intersect_res,
                   out_data_o.intersect_res);
        if (out_data_o.parallel !== e.parallel)
          $display("%0t parallel exp %0d got %0d", $time, e.parallel, out_data_o.parallel);
        if (out_data_o.collinear !== e.collinear)
          $display("%0t collinear exp %0d got %0d", $time, e.collinear,
                   out_data_o.collinear);
        if (out_data_o.param_r !== e.param_r)
          $display("%0t param_r exp %0d got %0d", $time, e.param_r, out_data_o.param_r);
        if (out_data_o.param_s !== e.param_s)
          $display("%0t param_s exp %0d got %0d", $time, e.param_s, out_data_o.param_s);
        if (out_data_o.point_x !== e.point_x)
          $display("%0t point_x exp %0d got %0d", $time, e.point_x, out_data_o.point_x);
        if (out_data_o.point_y !== e.point_y)
          $display("%0t point_y exp %0d got %0d", $time, e.point_y, out_data_o.point_y);
        if (out_data_o !== e) errors++;
      end
    end
  end

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_q.size() != 0);
  endtask

  task automatic test_directed();
    send_pts(0, 0, 10, 10, 0, 10, 10, 0);
    send_pts(0, 0, 10, 0, 0, 5, 10, 5);
    send_pts(0, 0, 10, 0, 20, 0, 30, 0);
    send_pts(0, 0, 0, 0, 0, 0, 0, 0);
    send_pts(0, 0, 10, 0, 10, -5, 10, 5);
    send_pts(0, 0, 10, 0, 20, -5, 20, 5);
    send_pts(0, 0, 3, 0, 1, -1, 1, 1);
    send_pts(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pts(-32768, 0, 32767, 0, 0, 32767, 1, -32768);
    send_pts(32767, 32767, 32767, 32766, -32768, -32768, -32767, -32768);
    send_pts(0, 0, 1, 0, 0, 0, 0, 1);
    send_pts(0, 0, 1, 1, -32768, 32767, 32767, -32767);
    send_pts(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
    send_pts(0, 0, 1, 0, 32767, 1, -32768, 0);
    send_pts(-1, -1, -1, -1, 5, 5, 9, 9);
  endtask

  task automatic test_pause();
    wait_drain();
    repeat (5) send_pts($urandom_range(0, 50), 0, 50, 50, 0, 50, 50, 0);
  endtask

  task automatic test_random();
    in_t t;
    int  k, m;
    for (int i = 0; i < 1000; i++) begin
      t = in_t'({$urandom, $urandom, $urandom, $urandom});
      k = $urandom_range(0, 3);
      m = $urandom_range(0, 5) == 0 ? 16 : $urandom_range(2, 8);
      if (k == 1) begin
        // small coordinates, frequent crossings
        t.ax = $signed(t.ax) >>> m; t.ay = $signed(t.ay) >>> m;
        t.bx = $signed(t.bx) >>> m; t.by_coord = $signed(t.by_coord) >>> m;
        t.cx = $signed(t.cx) >>> m; t.cy = $signed(t.cy) >>> m;
        t.dx_coord = $signed(t.dx_coord) >>> m; t.dy_coord = $signed(t.dy_coord) >>> m;
      end else if (k == 2) begin
        // parallel or collinear: CD offset along AB direction
        t.ax = $signed(t.ax) >>> 4; t.ay = $signed(t.ay) >>> 4;
        t.bx = t.ax + $signed(t.bx[7:0]); t.by_coord = t.ay + $signed(t.by_coord[7:0]);
        t.cx = IN_W'(($urandom_range(0, 1)) ? t.ax + 2 * (t.bx - t.ax)
                                            : t.ax + $signed(t.cx[3:0]));
        t.cy = IN_W'(($urandom_range(0, 1)) ? t.ay + 2 * (t.by_coord - t.ay)
                                            : t.cy >>> 4);
        t.dx_coord = IN_W'(t.cx + 3 * (t.bx - t.ax));
        t.dy_coord = IN_W'(t.cy + 3 * (t.by_coord - t.ay));
      end
      if (i == 500) sink_busy = 1'b0;
      if (i == 600) sink_busy = 1'b1;
      send_pair(t);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_pause();
    test_random();
    wait_drain();
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("Sent %0d segment pairs: %0d crossings, %0d parallel, %0d collinear.",
             n_sent, n_hit, n_par, n_col);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/segi_pkg.sv
rtl/segi_div.sv
rtl/segment_intersection_top.sv
bench/segment_intersection_top_tb.sv
